[rtl/core/sitp_pkg.sv]
// Shared types, constants and the character classifier for the string to
// integer parser. No dependencies.
`timescale 1ns / 1ps

package sitp_pkg;

  localparam int unsigned ValueWidth = 32;
  localparam int unsigned RadixWidth = 6;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueueIdxW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic [1:0] CmdStart   = 2'd0;
  localparam logic [1:0] CmdPush    = 2'd1;
  localparam logic [1:0] CmdFinUns  = 2'd2;
  localparam logic [1:0] CmdFinSgn  = 2'd3;

  localparam logic [7:0] ChSpace    = 8'h20;
  localparam logic [7:0] ChTab      = 8'h09;
  localparam logic [7:0] ChCr       = 8'h0D;
  localparam logic [7:0] ChMinus    = 8'h2D;
  localparam logic [7:0] ChPlus     = 8'h2B;
  localparam logic [7:0] ChZero     = 8'h30;
  localparam logic [7:0] ChNine     = 8'h39;
  localparam logic [7:0] ChLowA     = 8'h61;
  localparam logic [7:0] ChLowX     = 8'h78;
  localparam logic [7:0] ChCaseBit  = 8'h20;

  localparam logic [RadixWidth-1:0] RadixAuto  = 6'd0;
  localparam logic [RadixWidth-1:0] RadixMin   = 6'd2;
  localparam logic [RadixWidth-1:0] RadixMax   = 6'd36;
  localparam logic [RadixWidth-1:0] RadixOct   = 6'd8;
  localparam logic [RadixWidth-1:0] RadixDec   = 6'd10;
  localparam logic [RadixWidth-1:0] RadixHex   = 6'd16;
  localparam logic [RadixWidth-1:0] NoDigit    = 6'd63;

  localparam logic [ValueWidth-1:0] AllOnes    = 32'hFFFF_FFFF;
  localparam logic [ValueWidth-1:0] PosLimit   = 32'h7FFF_FFFF;
  localparam logic [ValueWidth-1:0] NegLimit   = 32'h8000_0000;

  // One classified item as it waits between front and back.
  typedef struct packed {
    logic [1:0]            cmd;
    logic [RadixWidth-1:0] radix;
    logic [RadixWidth-1:0] digit;    // NoDigit when no digit of any base
    logic                  is_blank;
    logic                  is_minus;
    logic                  is_plus;
    logic                  is_zero;
    logic                  is_x;
  } sitp_item_t;

  // Digit value 0..35, or NoDigit.
  function automatic logic [RadixWidth-1:0] digit_of(input logic [7:0] c);
    logic [7:0] lc;
    logic [7:0] d;
    lc = c | ChCaseBit;
    d  = lc - ChLowA + 8'd10;
    if (c >= ChZero && c <= ChNine) begin
      digit_of = RadixWidth'(c - ChZero);
    end else if (lc >= ChLowA && d < 8'(RadixMax)) begin
      digit_of = d[RadixWidth-1:0];
    end else begin
      digit_of = NoDigit;
    end
  endfunction

endpackage

[rtl/core/sitp_front.sv]
// Front end: takes input transfers and classifies the character.
// Depends on sitp_pkg.
`timescale 1ns / 1ps

module sitp_front (
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [1:0]                      command_i,
  input  logic [7:0]                      character_i,
  input  logic [sitp_pkg::RadixWidth-1:0] radix_i,
  input  logic                            q_full_i,
  output logic                            q_push_o,
  output sitp_pkg::sitp_item_t            q_item_o
);

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  always_comb begin
    q_item_o.cmd      = command_i;
    q_item_o.radix    = radix_i;
    q_item_o.digit    = sitp_pkg::digit_of(character_i);
    q_item_o.is_blank = (character_i == sitp_pkg::ChSpace) ||
                        (character_i >= sitp_pkg::ChTab && character_i <= sitp_pkg::ChCr);
    q_item_o.is_minus = (character_i == sitp_pkg::ChMinus);
    q_item_o.is_plus  = (character_i == sitp_pkg::ChPlus);
    q_item_o.is_zero  = (character_i == sitp_pkg::ChZero);
    q_item_o.is_x     = ((character_i | sitp_pkg::ChCaseBit) == sitp_pkg::ChLowX);
  end

endmodule

[rtl/core/sitp_queue.sv]
// Short queue of classified items between front and back.
// Depends on sitp_pkg.
`timescale 1ns / 1ps

module sitp_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  sitp_pkg::sitp_item_t item_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 valid_o,
  output sitp_pkg::sitp_item_t item_o
);

  sitp_pkg::sitp_item_t              slot_q [sitp_pkg::QueueDepth];
  logic [sitp_pkg::QueueIdxW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [sitp_pkg::QueueCntW-1:0]    cnt_q, cnt_d;
  logic                              do_pop;

  assign full_o  = (cnt_q == sitp_pkg::QueueCntW'(sitp_pkg::QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign item_o  = slot_q[rd_q];
  assign do_pop  = pop_i && valid_o;

  function automatic logic [sitp_pkg::QueueIdxW-1:0] next_idx(
      input logic [sitp_pkg::QueueIdxW-1:0] idx);
    if (idx == sitp_pkg::QueueIdxW'(sitp_pkg::QueueDepth - 1)) begin
      next_idx = '0;
    end else begin
      next_idx = idx + 1'b1;
    end
  endfunction

  always_comb begin
    wr_d  = push_i ? next_idx(wr_q) : wr_q;
    rd_d  = do_pop ? next_idx(rd_q) : rd_q;
    cnt_d = cnt_q + sitp_pkg::QueueCntW'(push_i) - sitp_pkg::QueueCntW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= item_i;
    end
  end

endmodule

[rtl/core/sitp_back.sv]
// Back end: conversion state, one multiply-add per digit, finish logic and
// the output register. Depends on sitp_pkg.
`timescale 1ns / 1ps

module sitp_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            q_valid_i,
  input  sitp_pkg::sitp_item_t            q_item_i,
  output logic                            q_pop_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            accepted_o,
  output logic [sitp_pkg::ValueWidth-1:0] result_value_o,
  output logic                            converted_o,
  output logic                            range_error_o
);

  localparam int unsigned ProdW = sitp_pkg::ValueWidth + sitp_pkg::RadixWidth;

  logic [sitp_pkg::ValueWidth-1:0] acc_q, acc_d;
  logic [sitp_pkg::RadixWidth-1:0] base_q, base_d;
  logic minus_q, minus_d, plus_q, plus_d, zp_q, zp_d;
  logic digit_q, digit_d, ovf_q, ovf_d, skip_q, skip_d;

  logic                            out_valid_q;
  logic                            acc_ok_q, conv_q, rerr_q;
  logic [sitp_pkg::ValueWidth-1:0] value_q;

  logic                            acc_ok, conv, rerr;
  logic [sitp_pkg::ValueWidth-1:0] value, neg_acc, lim;
  logic [sitp_pkg::RadixWidth-1:0] base_eff;
  logic [ProdW-1:0]                next_val;
  logic                            done, sign_ok;

  assign q_pop_o = q_valid_i && (!out_valid_q || !out_stall_i);

  assign neg_acc  = '0 - acc_q;
  assign lim      = minus_q ? sitp_pkg::NegLimit : sitp_pkg::PosLimit;

  always_comb begin
    acc_d    = acc_q;
    base_d   = base_q;
    minus_d  = minus_q;
    plus_d   = plus_q;
    zp_d     = zp_q;
    digit_d  = digit_q;
    ovf_d    = ovf_q;
    skip_d   = skip_q;
    acc_ok   = 1'b0;
    conv     = 1'b0;
    rerr     = 1'b0;
    value    = '0;
    done     = 1'b0;
    base_eff = base_q;
    sign_ok  = !minus_q && !plus_q && !zp_q && !digit_q && !ovf_q;
    next_val = ProdW'(acc_q) * ProdW'(base_q) + ProdW'(q_item_i.digit);

    case (q_item_i.cmd)
      sitp_pkg::CmdStart: begin
        acc_d   = '0;
        base_d  = q_item_i.radix;
        minus_d = 1'b0;
        plus_d  = 1'b0;
        zp_d    = 1'b0;
        digit_d = 1'b0;
        ovf_d   = 1'b0;
        skip_d  = 1'b1;
      end
      sitp_pkg::CmdPush: begin
        if (skip_q && q_item_i.is_blank) begin
          acc_ok = 1'b1;
          done   = 1'b1;
        end else begin
          skip_d = 1'b0;
        end
        if (!done && sign_ok && q_item_i.is_minus) begin
          minus_d = 1'b1;
          acc_ok  = 1'b1;
          done    = 1'b1;
        end else if (!done && sign_ok && q_item_i.is_plus) begin
          plus_d = 1'b1;
          acc_ok = 1'b1;
          done   = 1'b1;
        end
        // Auto radix: prefix detection picks the base once.
        if (!done && base_q == sitp_pkg::RadixAuto) begin
          if (zp_q) begin
            if (q_item_i.is_x) begin
              base_d = sitp_pkg::RadixHex;
              acc_ok = 1'b1;
              done   = 1'b1;
            end else begin
              base_d   = sitp_pkg::RadixOct;
              base_eff = sitp_pkg::RadixOct;
            end
          end else if (q_item_i.is_zero) begin
            zp_d    = 1'b1;
            digit_d = 1'b1;
            acc_ok  = 1'b1;
            done    = 1'b1;
          end else begin
            base_d   = sitp_pkg::RadixDec;
            base_eff = sitp_pkg::RadixDec;
          end
        end
        if (!done && base_eff >= sitp_pkg::RadixMin && base_eff <= sitp_pkg::RadixMax &&
            q_item_i.digit < base_eff) begin
          // Accumulator is zero in auto mode here, so the product with the
          // stale base is zero as well; only the digit matters.
          acc_ok  = 1'b1;
          digit_d = 1'b1;
          if (|next_val[ProdW-1:sitp_pkg::ValueWidth]) begin
            ovf_d = 1'b1;
            acc_d = sitp_pkg::AllOnes;
          end else begin
            acc_d = next_val[sitp_pkg::ValueWidth-1:0];
          end
        end
      end
      sitp_pkg::CmdFinUns: begin
        if (digit_q) begin
          conv = 1'b1;
          if (ovf_q) begin
            value = sitp_pkg::AllOnes;
            rerr  = 1'b1;
          end else begin
            value = minus_q ? neg_acc : acc_q;
          end
        end
      end
      sitp_pkg::CmdFinSgn: begin
        if (digit_q) begin
          conv = 1'b1;
          if (ovf_q || acc_q > lim) begin
            value = lim;
            rerr  = 1'b1;
          end else begin
            value = minus_q ? neg_acc : acc_q;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      base_q      <= sitp_pkg::RadixAuto;
      minus_q     <= 1'b0;
      plus_q      <= 1'b0;
      zp_q        <= 1'b0;
      digit_q     <= 1'b0;
      ovf_q       <= 1'b0;
      skip_q      <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (q_pop_o) begin
        acc_q   <= acc_d;
        base_q  <= base_d;
        minus_q <= minus_d;
        plus_q  <= plus_d;
        zp_q    <= zp_d;
        digit_q <= digit_d;
        ovf_q   <= ovf_d;
        skip_q  <= skip_d;
      end
      if (q_pop_o) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      acc_ok_q <= acc_ok;
      value_q  <= value;
      conv_q   <= conv;
      rerr_q   <= rerr;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign accepted_o     = acc_ok_q;
  assign result_value_o = value_q;
  assign converted_o    = conv_q;
  assign range_error_o  = rerr_q;

endmodule

[rtl/core/string_to_integer_parser.sv]
// Top level of the string to integer parser: front classifier, item queue
// and execution back end. Depends on sitp_pkg, sitp_front, sitp_queue, sitp_back.
`timescale 1ns / 1ps

// Takes one command per transfer (start with a radix, push a character,
// finish unsigned or signed) and returns exactly one result transfer per
// command. Sustained rate is one command per clock while the output is not
// stalled; a taken command is first written into the two-entry queue, then
// the back end pops it and loads the output register, from which the result
// transfer is made. The pace is set by the back end, which does the 32 by 6
// bit multiply-add of a digit and the state update combinationally. The
// queue lets the input keep flowing for up to two items while the output
// is stalled.
module string_to_integer_parser (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [1:0]                      command_i,
  input  logic [7:0]                      character_i,
  input  logic [sitp_pkg::RadixWidth-1:0] radix_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            accepted_o,
  output logic [sitp_pkg::ValueWidth-1:0] result_value_o,
  output logic                            converted_o,
  output logic                            range_error_o
);

  logic                 q_push, q_full, q_pop, q_valid;
  sitp_pkg::sitp_item_t q_in, q_out;

  sitp_front u_front (
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .command_i   (command_i),
    .character_i (character_i),
    .radix_i     (radix_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_item_o    (q_in)
  );

  sitp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_out)
  );

  sitp_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_item_i       (q_out),
    .q_pop_o        (q_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .accepted_o     (accepted_o),
    .result_value_o (result_value_o),
    .converted_o    (converted_o),
    .range_error_o  (range_error_o)
  );

endmodule

[rtl/core/sitp_checker.sv]
// Port-level checks for string_to_integer_parser, bound to the top level.
// Depends on sitp_pkg.
`timescale 1ns / 1ps

module sitp_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic                            accepted_o,
  input logic [sitp_pkg::ValueWidth-1:0] result_value_o,
  input logic                            converted_o,
  input logic                            range_error_o
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(result_value_o) &&
    $stable(accepted_o) && $stable(converted_o) && $stable(range_error_o))
    else $error("result changed while stalled");

  // A push result never carries finish fields.
  a_push_or_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && accepted_o |-> !converted_o && !range_error_o &&
    result_value_o == '0)
    else $error("accepted push carries finish fields");

  a_rerr_needs_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && range_error_o |-> converted_o)
    else $error("range error without a converted digit");

  a_no_digit_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !converted_o |-> result_value_o == '0)
    else $error("nonzero value without conversion");

endmodule

bind string_to_integer_parser sitp_checker u_sitp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .accepted_o     (accepted_o),
  .result_value_o (result_value_o),
  .converted_o    (converted_o),
  .range_error_o  (range_error_o)
);

[test/testbench.sv]
// Self-checking testbench for string_to_integer_parser: a queue-fed driver, a
// stall-toggling monitor and a command-level predictor of the parser state.
// Depends on sitp_pkg and the string_to_integer_parser RTL.
`timescale 1ns / 1ps

module testbench;
  import sitp_pkg::*;

  localparam int unsigned PhaseItems    = 430;
  localparam int unsigned HoldAfter     = 150;  // results seen before the long output hold
  localparam int unsigned HoldCycles    = 64;
  localparam int unsigned WatchdogLimit = 2000;

  typedef struct packed {
    logic [1:0]            cmd;
    logic [7:0]            ch;
    logic [RadixWidth-1:0] radix;
  } parse_cmd_t;

  typedef struct packed {
    logic                  accepted;
    logic [ValueWidth-1:0] value;
    logic                  converted;
    logic                  range_err;
  } parse_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [1:0]            command = CmdStart;
  logic [7:0]            character = '0;
  logic [RadixWidth-1:0] radix = RadixAuto;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  accepted;
  logic [ValueWidth-1:0] result_value;
  logic                  converted;
  logic                  range_error;

  parse_cmd_t    commands_todo[$];
  parse_result_t results_due[$];
  parse_cmd_t    driven_item;
  parse_cmd_t    next_item;
  parse_result_t due_r;

  int unsigned items_queued  = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned results_seen  = 0;
  int unsigned hold_left     = 0;
  logic        hold_done     = 1'b0;
  int unsigned fail_count    = 0;
  int unsigned idle_cycles   = 0;

  // predictor state, reset equals a start with auto radix
  logic [ValueWidth-1:0] acc_value  = '0;
  logic [RadixWidth-1:0] cur_base   = RadixAuto;
  logic                  minus_seen = 1'b0;
  logic                  plus_seen  = 1'b0;
  logic                  zero_lead  = 1'b0;
  logic                  have_digit = 1'b0;
  logic                  sticky_ovf = 1'b0;
  logic                  in_blanks  = 1'b1;

  string_to_integer_parser dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .command_i      (command),
    .character_i    (character),
    .radix_i        (radix),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .accepted_o     (accepted),
    .result_value_o (result_value),
    .converted_o    (converted),
    .range_error_o  (range_error)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Advances the predicted parser by one command and returns its result.
  function automatic parse_result_t parse_step(parse_cmd_t it);
    parse_result_t         r;
    logic [31:0]           dv;
    logic [ValueWidth-1:0] lim;
    logic [63:0]           prod;
    logic [7:0]            lc;
    r = '0;
    case (it.cmd)
      CmdStart: begin
        acc_value  = '0;
        cur_base   = it.radix;
        minus_seen = 1'b0;
        plus_seen  = 1'b0;
        zero_lead  = 1'b0;
        have_digit = 1'b0;
        sticky_ovf = 1'b0;
        in_blanks  = 1'b1;
        return r;
      end
      CmdPush: begin
        r.accepted = 1'b1;
        if (in_blanks) begin
          if (it.ch == ChSpace || (it.ch >= ChTab && it.ch <= ChCr)) return r;
          in_blanks = 1'b0;
        end
        if (!(minus_seen || plus_seen || zero_lead || have_digit || sticky_ovf)) begin
          if (it.ch == ChMinus) begin
            minus_seen = 1'b1;
            return r;
          end
          if (it.ch == ChPlus) begin
            plus_seen = 1'b1;
            return r;
          end
        end
        // auto radix: base choice sticks even if this byte is rejected below
        if (cur_base == RadixAuto) begin
          if (zero_lead) begin
            if ((it.ch | ChCaseBit) == ChLowX) begin
              cur_base = RadixHex;
              return r;
            end
            cur_base = RadixOct;
          end else if (it.ch == ChZero) begin
            zero_lead  = 1'b1;
            have_digit = 1'b1;
            return r;
          end else begin
            cur_base = RadixDec;
          end
        end
        lc = it.ch | ChCaseBit;
        if (it.ch >= ChZero && it.ch <= ChNine) dv = 32'(it.ch - ChZero);
        else if (lc >= ChLowA) dv = 32'(lc) - 32'(ChLowA) + 32'd10;
        else dv = 32'hFFFF_FFFF;
        if (cur_base < RadixMin || cur_base > RadixMax || dv >= 32'(cur_base)) begin
          r.accepted = 1'b0;
          return r;
        end
        have_digit = 1'b1;
        prod = 64'(acc_value) * 64'(cur_base) + 64'(dv);
        if (prod > 64'(AllOnes)) begin
          sticky_ovf = 1'b1;
          acc_value  = AllOnes;
        end else begin
          acc_value = prod[31:0];
        end
        return r;
      end
      default: begin
        if (!have_digit) return r;
        r.converted = 1'b1;
        lim = minus_seen ? NegLimit : PosLimit;
        if (it.cmd == CmdFinUns) begin
          if (sticky_ovf) begin
            r.value     = AllOnes;
            r.range_err = 1'b1;
          end else begin
            r.value = minus_seen ? -acc_value : acc_value;
          end
        end else if (sticky_ovf || acc_value > lim) begin
          r.value     = lim;
          r.range_err = 1'b1;
        end else begin
          r.value = minus_seen ? -acc_value : acc_value;
        end
        return r;
      end
    endcase
  endfunction

  function automatic logic [7:0] digit_char(int unsigned d);
    logic [7:0] c;
    if (d < 10) return ChZero + 8'(d);
    c = ChLowA + 8'(d - 10);
    return $urandom_range(1) ? (c ^ ChCaseBit) : c;
  endfunction

  task automatic queue_cmd(logic [1:0] cmd, logic [7:0] ch, logic [RadixWidth-1:0] rdx);
    parse_cmd_t it;
    it.cmd   = cmd;
    it.ch    = ch;
    it.radix = rdx;
    commands_todo.push_back(it);
    items_queued++;
  endtask

  task automatic queue_push(logic [7:0] ch);
    queue_cmd(CmdPush, ch, RadixWidth'($urandom_range(63)));
  endtask

  // One start ... finish sequence with random content and some noise bytes.
  task automatic queue_number();
    int unsigned rdx;
    int unsigned base;
    int unsigned pick;
    int unsigned ndig;
    logic [31:0] val;
    logic [7:0]  digs[$];
    pick = $urandom_range(99);
    if (pick < 35) rdx = RadixAuto;
    else if (pick < 80) rdx = $urandom_range(36, 2);
    else if (pick < 85) rdx = RadixHex;
    else if (pick < 90) rdx = RadixOct;
    else rdx = $urandom_range(63);
    queue_cmd(CmdStart, 8'($urandom_range(255)), RadixWidth'(rdx));
    repeat ($urandom_range(3))
      queue_push($urandom_range(1) ? ChSpace : 8'($urandom_range(ChCr, ChTab)));
    pick = $urandom_range(3);
    if (pick == 0) queue_push(ChMinus);
    else if (pick == 1) queue_push(ChPlus);
    base = rdx;
    if (rdx == RadixAuto) begin
      pick = $urandom_range(2);
      if (pick == 0) begin
        queue_push(ChZero);
        queue_push($urandom_range(1) ? ChLowX : (ChLowX ^ ChCaseBit));
        base = RadixHex;
      end else if (pick == 1) begin
        queue_push(ChZero);
        base = RadixOct;
      end else begin
        base = RadixDec;
      end
    end
    if (base < RadixMin || base > RadixMax) base = RadixMax;
    if ($urandom_range(3) == 0) begin
      // values at the unsigned and signed limits, zero or a random value, written in the active base
      case ($urandom_range(5))
        0: val = PosLimit;
        1: val = NegLimit;
        2: val = NegLimit + 1;
        3: val = AllOnes;
        4: val = '0;
        default: val = $urandom;
      endcase
      do begin
        digs.push_front(digit_char(val % base));
        val = val / base;
      end while (val != 0);
    end else begin
      ndig = ($urandom_range(9) == 0) ? $urandom_range(40, 12) : $urandom_range(8);
      repeat (ndig) digs.push_back(digit_char($urandom_range(base - 1)));
    end
    foreach (digs[i]) begin
      if ($urandom_range(99) < 8) queue_push(8'($urandom_range(255)));
      else queue_push(digs[i]);
    end
    repeat ($urandom_range(2, 1))
      queue_cmd($urandom_range(1) ? CmdFinUns : CmdFinSgn, 8'($urandom_range(255)),
                RadixWidth'($urandom_range(63)));
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (commands_todo.size() != 0 || in_valid || results_due.size() != 0);
  endtask

  // Driver: a new item is only picked once the current one has transferred.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) results_due.push_back(parse_step(driven_item));
      if (!in_valid || !in_stall) begin
        if (commands_todo.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_item   = commands_todo.pop_front();
          driven_item = next_item;
          in_valid  <= 1'b1;
          command   <= next_item.cmd;
          character <= next_item.ch;
          radix     <= next_item.radix;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result transfer, drives random stalls and one long hold.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen <= results_seen + 1;
        if (results_due.size() == 0) begin
          $error("result transfer with no command outstanding");
          fail_count++;
        end else begin
          due_r = results_due.pop_front();
          if (accepted !== due_r.accepted) begin
            $error("accepted: expected %0d, got %0d", due_r.accepted, accepted);
            fail_count++;
          end
          if (result_value !== due_r.value) begin
            $error("result_value: expected %h, got %h", due_r.value, result_value);
            fail_count++;
          end
          if (converted !== due_r.converted) begin
            $error("converted: expected %0d, got %0d", due_r.converted, converted);
            fail_count++;
          end
          if (range_error !== due_r.range_err) begin
            $error("range_error: expected %0d, got %0d", due_r.range_err, range_error);
            fail_count++;
          end
        end
      end
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (!hold_done && results_seen >= HoldAfter) begin
        hold_left <= HoldCycles;
        hold_done <= 1'b1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
        $display("Test completed with failures");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int unsigned target;
    // finish before any start: reset state has no digit
    queue_cmd(CmdFinSgn, 8'hFF, 6'h3F);
    queue_cmd(CmdStart, 8'h00, RadixAuto);
    queue_push(ChSpace);
    queue_push(ChCr);
    queue_push(ChMinus);
    queue_push(ChZero);
    queue_push(ChLowX ^ ChCaseBit);
    queue_push("f");
    queue_push("F");
    queue_push("g");
    queue_cmd(CmdFinUns, 8'h00, RadixAuto);
    // base 36, seven top digits overflow
    queue_cmd(CmdStart, 8'hFF, RadixMax);
    repeat (7) queue_push("Z");
    queue_cmd(CmdFinSgn, 8'h00, 6'h00);
    queue_push(8'hFF);
    // unusable radixes take blanks and signs but no digit
    queue_cmd(CmdStart, 8'h00, 6'h3F);
    queue_push(ChPlus);
    queue_push("1");
    queue_cmd(CmdFinUns, 8'h00, 6'h00);
    queue_cmd(CmdStart, 8'h00, 6'd1);
    queue_push(8'h00);
    queue_cmd(CmdFinSgn, 8'h00, 6'h00);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait_idle();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 68; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 68; end
        default: begin send_idle_pct = 38; stall_pct = 38; end
      endcase
      target = items_queued + PhaseItems;
      while (items_queued < target) begin
        if ($urandom_range(9) == 0) begin
          repeat ($urandom_range(6, 1))
            queue_cmd(2'($urandom_range(3)), 8'($urandom_range(255)),
                      RadixWidth'($urandom_range(63)));
        end else begin
          queue_number();
        end
      end
      wait_idle();
    end

    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
